// File: design/assert_macros.svh
// Assertion macros shared by the keypad event latch RTL.
// Checks compile in for simulation and drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define MKEL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MKEL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MKEL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MKEL_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: design/mkel_pkg.sv
// Shared types and constants for the matrix keypad event latch.
// No dependencies; every module of the block imports this package.
package mkel_pkg;

    localparam int MAX_ROWS_DEF = 4;
    localparam int MAX_COLS_DEF = 4;
    localparam int MATRIX_W     = 16;
    localparam int CODE_W       = 8;
    localparam int COUNT_W      = 3;
    localparam int WORD_W       = 32;
    localparam int KEYMAP_WORDS = 4;
    localparam int KEY_ENTRIES  = 16;
    localparam int MAP_IDX_W    = 7;
    localparam int KEY_SEL_W    = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int ACTION_W     = 2;

    localparam logic [COUNT_W-1:0] ROW_COUNT_RST = 3'd4;
    localparam logic [COUNT_W-1:0] COL_COUNT_RST = 3'd4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP3   = 3'd5;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_SCAN  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

    localparam logic [CODE_W-1:0] NO_KEY = 8'd0;

    typedef struct packed {
        logic [COUNT_W-1:0]                   row_count;
        logic [COUNT_W-1:0]                   col_count;
        logic [KEYMAP_WORDS-1:0][WORD_W-1:0]  keymap;
    } cfg_t;

    typedef struct packed {
        logic                advance;
        logic [ACTION_W-1:0] action;
        logic [CODE_W-1:0]   scan_code;
    } evt_req_t;

endpackage

// File: design/matrix_keypad_event_latch_top.sv
// Matrix keypad event latch, top level.
// An accepted request is held in the input register until the result register has room.
// Throughput: one request per cycle. While a result waits, the input register takes one more
// request, then s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): both stages empty, key buffer and last scan code zero,
// rows and columns 4, keymap all zero.
module matrix_keypad_event_latch_top #(
    parameter int MAX_ROWS = mkel_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mkel_pkg::MAX_COLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mkel_pkg::ACTION_W-1:0]     s_action,
    input  logic [mkel_pkg::MATRIX_W-1:0]     s_pressed_matrix,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mkel_pkg::CODE_W-1:0]       m_key_code,
    output logic                              m_key_waiting,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mkel_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mkel_pkg::WORD_W-1:0]       cfg_data
);
    import mkel_pkg::*;

    cfg_t                cfg;
    evt_req_t            req;
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [ACTION_W-1:0] action_reg;
    logic [MATRIX_W-1:0] matrix_reg;
    logic [CODE_W-1:0]   scan_code;
    logic                advance;

    // move the held request into the result register when it has room
    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            matrix_reg <= s_pressed_matrix;
        end
    end

    mkel_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mkel_scan #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_scan (
        .pressed_matrix (matrix_reg),
        .cfg            (cfg),
        .scan_code      (scan_code)
    );

    assign req.advance   = advance;
    assign req.action    = action_reg;
    assign req.scan_code = scan_code;

    mkel_event u_event (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req           (req),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_key_code    (m_key_code),
        .m_key_waiting (m_key_waiting)
    );

endmodule

// File: design/mkel_cfg_regs.sv
// Configuration register file: key matrix size and the 16-entry keymap.
// Depends on mkel_pkg.
module mkel_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mkel_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mkel_pkg::WORD_W-1:0]       cfg_data,
    output mkel_pkg::cfg_t                    cfg
);
    import mkel_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ROW_COUNT: cfg_next.row_count = cfg_data[COUNT_W-1:0];
                CFG_COL_COUNT: cfg_next.col_count = cfg_data[COUNT_W-1:0];
                CFG_KEYMAP0:   cfg_next.keymap[0] = cfg_data;
                CFG_KEYMAP1:   cfg_next.keymap[1] = cfg_data;
                CFG_KEYMAP2:   cfg_next.keymap[2] = cfg_data;
                CFG_KEYMAP3:   cfg_next.keymap[3] = cfg_data;
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_count <= ROW_COUNT_RST;
            cfg_reg.col_count <= COL_COUNT_RST;
            cfg_reg.keymap    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/mkel_scan.sv
// Scan decoder: picks the last pressed active key and looks up its code.
// Depends on mkel_pkg.
module mkel_scan #(
    parameter int MAX_ROWS = mkel_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mkel_pkg::MAX_COLS_DEF
) (
    input  logic [mkel_pkg::MATRIX_W-1:0] pressed_matrix,
    input  mkel_pkg::cfg_t                cfg,
    output logic [mkel_pkg::CODE_W-1:0]   scan_code
);
    import mkel_pkg::*;

    logic [COUNT_W:0]                  rows;
    logic [COUNT_W:0]                  cols;
    logic [MATRIX_W-1:0]               active;
    logic [MATRIX_W-1:0]               active_rev;
    logic [MATRIX_W-1:0]               low_rev;
    logic [MATRIX_W-1:0]               last_hot;
    logic [MAP_IDX_W-1:0]              map_idx [MATRIX_W];
    logic [MAP_IDX_W-1:0]              sel_idx;
    logic [KEY_ENTRIES-1:0][CODE_W-1:0] keymap_bytes;

    // clamp counts to the physical matrix size
    assign rows = ({1'b0, cfg.row_count} > (COUNT_W+1)'(MAX_ROWS)) ?
                  (COUNT_W+1)'(MAX_ROWS) : {1'b0, cfg.row_count};
    assign cols = ({1'b0, cfg.col_count} > (COUNT_W+1)'(MAX_COLS)) ?
                  (COUNT_W+1)'(MAX_COLS) : {1'b0, cfg.col_count};

    assign keymap_bytes = cfg.keymap;

    for (genvar b = 0; b < MATRIX_W; b++) begin : g_bit
        localparam int R = b / MAX_COLS;
        localparam int C = b % MAX_COLS;
        assign active[b] = pressed_matrix[b] && (R < MAX_ROWS) &&
                           ((COUNT_W+1)'(R) < rows) && ((COUNT_W+1)'(C) < cols);
        assign map_idx[b] = MAP_IDX_W'(MAP_IDX_W'(R) * MAP_IDX_W'(cols) + MAP_IDX_W'(C));
    end

    // isolate the highest set bit: reverse, keep lowest, reverse back
    always_comb begin
        for (int b = 0; b < MATRIX_W; b++) begin
            active_rev[b] = active[MATRIX_W-1-b];
        end
        low_rev = active_rev & (~active_rev + MATRIX_W'(1));
        for (int b = 0; b < MATRIX_W; b++) begin
            last_hot[b] = low_rev[MATRIX_W-1-b];
        end
    end

    always_comb begin
        sel_idx = '0;
        for (int b = 0; b < MATRIX_W; b++) begin
            sel_idx = sel_idx | ({MAP_IDX_W{last_hot[b]}} & map_idx[b]);
        end
    end

    assign scan_code = ((|active) && (sel_idx < MAP_IDX_W'(KEY_ENTRIES))) ?
                       keymap_bytes[sel_idx[KEY_SEL_W-1:0]] : NO_KEY;

endmodule

// File: design/mkel_event.sv
// Event state and result register: previous scan code, one-slot key buffer.
// Depends on mkel_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mkel_event (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mkel_pkg::evt_req_t            req,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [mkel_pkg::CODE_W-1:0]   m_key_code,
    output logic                          m_key_waiting
);
    import mkel_pkg::*;

    logic [CODE_W-1:0] prev_code_reg;
    logic [CODE_W-1:0] prev_code_next;
    logic [CODE_W-1:0] held_code_reg;
    logic [CODE_W-1:0] held_code_next;
    logic [CODE_W-1:0] key_code_reg;
    logic [CODE_W-1:0] key_code_next;
    logic              key_waiting_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_comb begin
        prev_code_next = prev_code_reg;
        held_code_next = held_code_reg;
        key_code_next  = NO_KEY;
        unique case (req.action)
            ACT_SCAN: begin
                if (req.scan_code != prev_code_reg) begin
                    prev_code_next = req.scan_code;
                    if (req.scan_code != NO_KEY) begin
                        held_code_next = req.scan_code;
                    end
                end
            end
            ACT_READ: begin
                key_code_next  = held_code_reg;
                held_code_next = NO_KEY;
            end
            ACT_FLUSH: begin
                held_code_next = NO_KEY;
            end
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (req.advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_code_reg <= NO_KEY;
            held_code_reg <= NO_KEY;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (req.advance) begin
                prev_code_reg <= prev_code_next;
                held_code_reg <= held_code_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.advance) begin
            key_code_reg    <= key_code_next;
            key_waiting_reg <= (held_code_next != NO_KEY);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_key_code    = key_code_reg;
    assign m_key_waiting = key_waiting_reg;

    `MKEL_ASSERT_NXT(a_read_empties, aclk, aresetn, req.advance && (req.action == ACT_READ), !key_waiting_reg && (held_code_reg == NO_KEY))
    `MKEL_ASSERT_NXT(a_code_only_on_read, aclk, aresetn, req.advance && (req.action != ACT_READ), key_code_reg == NO_KEY)
    `MKEL_ASSERT_IMP(a_waiting_tracks_buffer, aclk, aresetn, out_valid_reg, key_waiting_reg == (held_code_reg != NO_KEY))
    `MKEL_ASSERT_NXT(a_state_holds_when_idle, aclk, aresetn, !req.advance, $stable(held_code_reg) && $stable(prev_code_reg))

endmodule
